[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Transaction types, cell constants and the microcode word layout shared by
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        did_scroll;
  } tcw_res_t;

  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic        CMD_PUT      = 1'b0;
  localparam logic        CMD_READ     = 1'b1;
  localparam logic        CFG_FORE     = 1'b0;
  localparam logic        CFG_BACK     = 1'b1;
  localparam logic [3:0]  FORE_RESET   = 4'd7;
  localparam logic [3:0]  BACK_RESET   = 4'd0;

  // Microcode step addresses.
  typedef logic [3:0] upc_t;
  localparam upc_t U_CLR      = 4'd0;
  localparam upc_t U_IDLE     = 4'd1;
  localparam upc_t U_DISP     = 4'd2;
  localparam upc_t U_DISP2    = 4'd3;
  localparam upc_t U_PUT      = 4'd4;
  localparam upc_t U_NL       = 4'd5;
  localparam upc_t U_CHK      = 4'd6;
  localparam upc_t U_SC_PRIME = 4'd7;
  localparam upc_t U_SC_COPY  = 4'd8;
  localparam upc_t U_SC_BLANK = 4'd9;
  localparam upc_t U_SC_END   = 4'd10;
  localparam upc_t U_RD       = 4'd11;
  localparam upc_t U_RD2      = 4'd12;
  localparam upc_t U_DONE     = 4'd13;

  typedef enum logic [1:0] {
    WS_NONE,
    WS_BLANK,
    WS_COPY,
    WS_PUT
  } wsrc_e;

  typedef enum logic [1:0] {
    RS_NONE,
    RS_ROW,
    RS_ROW1,
    RS_REQ
  } rsrc_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_CLR,
    PTR_KEEP
  } ptr_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_NEWROW,
    CUR_BOTTOM
  } cur_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_IS_READ,
    C_IS_NL,
    C_NO_OVF,
    C_NOT_LAST_COPY,
    C_NOT_LAST_CELL
  } cond_e;

  typedef struct packed {
    logic    idle;
    wsrc_e   wsrc;
    rsrc_e   rsrc;
    ptr_op_e ptr_op;
    cur_op_e cur_op;
    logic    load_cell;
    logic    emit;
    cond_e   cond;
    upc_t    target;
  } tcw_uword_t;

  typedef struct packed {
    logic start;
    logic is_read;
    logic is_nl;
    logic ovf;
    logic last_copy;
    logic last_cell;
  } tcw_flags_t;

endpackage

[rtl/tcw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcw_useq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console microsequencer
// Step counter and control store; each step issues one control word and
// either falls through or takes a conditional jump.
// ----------------------------------------------------------------------------
module tcw_useq
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tcw_flags_t flags_i,
  output tcw_uword_t uword_o
);

  upc_t       upc_q;
  upc_t       upc_d;
  tcw_uword_t uw;
  logic       take;

  function automatic tcw_uword_t rom(input upc_t a);
    tcw_uword_t w;
    w.idle      = 1'b0;
    w.wsrc      = WS_NONE;
    w.rsrc      = RS_NONE;
    w.ptr_op    = PTR_HOLD;
    w.cur_op    = CUR_HOLD;
    w.load_cell = 1'b0;
    w.emit      = 1'b0;
    w.cond      = C_NEVER;
    w.target    = U_IDLE;
    case (a)
      U_CLR: begin
        w.wsrc   = WS_BLANK;
        w.ptr_op = PTR_INC;
        w.cond   = C_NOT_LAST_CELL;
        w.target = U_CLR;
      end
      U_IDLE: begin
        w.idle   = 1'b1;
        w.cond   = C_NOT_START;
        w.target = U_IDLE;
      end
      U_DISP: begin
        w.cond   = C_IS_READ;
        w.target = U_RD;
      end
      U_DISP2: begin
        w.cond   = C_IS_NL;
        w.target = U_NL;
      end
      U_PUT: begin
        w.wsrc   = WS_PUT;
        w.cur_op = CUR_ADV;
        w.cond   = C_ALWAYS;
        w.target = U_CHK;
      end
      U_NL: begin
        w.cur_op = CUR_NEWROW;
      end
      U_CHK: begin
        w.ptr_op = PTR_CLR;
        w.cond   = C_NO_OVF;
        w.target = U_DONE;
      end
      U_SC_PRIME: begin
        w.rsrc = RS_ROW;
      end
      U_SC_COPY: begin
        w.wsrc   = WS_COPY;
        w.rsrc   = RS_ROW1;
        w.ptr_op = PTR_INC;
        w.cond   = C_NOT_LAST_COPY;
        w.target = U_SC_COPY;
      end
      U_SC_BLANK: begin
        w.wsrc   = WS_BLANK;
        w.ptr_op = PTR_INC;
        w.cond   = C_NOT_LAST_CELL;
        w.target = U_SC_BLANK;
      end
      U_SC_END: begin
        w.cur_op = CUR_BOTTOM;
        w.cond   = C_ALWAYS;
        w.target = U_DONE;
      end
      U_RD: begin
        w.rsrc = RS_REQ;
      end
      U_RD2: begin
        w.load_cell = 1'b1;
      end
      U_DONE: begin
        w.emit   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

  assign uw = rom(upc_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:         take = 1'b0;
      C_ALWAYS:        take = 1'b1;
      C_NOT_START:     take = !flags_i.start;
      C_IS_READ:       take = flags_i.is_read;
      C_IS_NL:         take = flags_i.is_nl;
      C_NO_OVF:        take = !flags_i.ovf;
      C_NOT_LAST_COPY: take = !flags_i.last_copy;
      C_NOT_LAST_CELL: take = !flags_i.last_cell;
      default:         take = 1'b0;
    endcase
    upc_d = take ? uw.target : upc_q + upc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLR;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign uword_o = uw;

endmodule

[rtl/text_console_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console with a cursor, colour registers, scrolling and
// single-cell read-back, run by a microcoded sequencer over one cell RAM.
// ----------------------------------------------------------------------------
//  Channel   Ports                            Transaction
//  command   start, busy, in_i                start high while busy is low
//  result    res_strobe_o, res_o              one cycle per strobe
//  config    cfg_we_i, cfg_idx_i, cfg_data_i  every cycle with cfg_we_i high
//
// A read passes the dispatch, read and done steps, and a put or newline the
// dispatch, put or newline, check and done steps; the result strobe comes in the
// same cycle that busy falls. A put or newline that scrolls also copies each row
// up and blanks the bottom row: the single RAM port pair moves one cell per cycle.
// After reset the block clears the screen with busy high.
// Results cannot be held off, so nothing ever stalls inside the block.
// ----------------------------------------------------------------------------
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  tcw_in_t    in_i,
  output logic       res_strobe_o,
  output tcw_res_t   res_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  localparam int CellCount = SCREEN_ROWS * SCREEN_COLS;
  localparam int AddrW     = $clog2(CellCount);
  localparam int RowW      = $clog2(SCREEN_ROWS + 1);
  localparam int ColW      = $clog2(SCREEN_COLS);
  localparam int SelRW     = (RowW > 5) ? RowW : 5;
  localparam int SelCW     = (ColW > 7) ? ColW : 7;

  localparam logic [AddrW-1:0] LastCell = AddrW'(CellCount - 1);
  localparam logic [AddrW-1:0] LastCopy = AddrW'(CellCount - SCREEN_COLS - 1);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(SCREEN_COLS);
  localparam logic [AddrW-1:0] RowStep1 = AddrW'(SCREEN_COLS + 1);
  localparam logic [RowW-1:0]  RowLimit = RowW'(SCREEN_ROWS);
  localparam logic [RowW-1:0]  RowLast  = RowW'(SCREEN_ROWS - 1);
  localparam logic [ColW-1:0]  ColLast  = ColW'(SCREEN_COLS - 1);

  tcw_uword_t uw;
  tcw_flags_t flags;

  tcw_in_t          req_q;
  logic [3:0]       fore_q;
  logic [3:0]       back_q;
  logic [AddrW-1:0] ptr_q;
  logic [AddrW-1:0] ptr_d;
  logic [RowW-1:0]  row_q;
  logic [RowW-1:0]  row_d;
  logic [ColW-1:0]  col_q;
  logic [ColW-1:0]  col_d;
  logic [15:0]      cell_q;
  logic             scroll_q;
  logic             strobe_q;
  tcw_res_t         res_q;

  logic             accept;
  logic             in_range;
  logic [SelRW-1:0] sel_row;
  logic [SelCW-1:0] sel_col;
  logic [SelRW-1:0] row_ext;
  logic [SelCW-1:0] col_ext;
  logic [AddrW-1:0] lin_addr;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [15:0]      ram_rdata;

  tcw_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uw)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CellCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = !uw.idle;
  assign accept = start && !busy;

  assign row_ext  = SelRW'(row_q);
  assign col_ext  = SelCW'(col_q);
  assign in_range = (32'(req_q.read_row) < SCREEN_ROWS) &&
                    (32'(req_q.read_col) < SCREEN_COLS);

  assign flags.start     = start;
  assign flags.is_read   = (req_q.cmd == CMD_READ);
  assign flags.is_nl     = (req_q.char_code == NEWLINE_CODE);
  assign flags.ovf       = (row_q >= RowLimit);
  assign flags.last_copy = (ptr_q == LastCopy);
  assign flags.last_cell = (ptr_q == LastCell);

  always_comb begin
    if (uw.rsrc == RS_REQ) begin
      sel_row = SelRW'(req_q.read_row);
      sel_col = SelCW'(req_q.read_col);
    end else begin
      sel_row = row_ext;
      sel_col = col_ext;
    end
    lin_addr = AddrW'(sel_row * AddrW'(SCREEN_COLS)) + AddrW'(sel_col);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = BLANK_CELL;
    case (uw.wsrc)
      WS_NONE:  ram_we = 1'b0;
      WS_BLANK: ram_we = 1'b1;
      WS_COPY: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      WS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lin_addr;
        ram_wdata = {back_q, fore_q, req_q.char_code};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_q + RowStep;
    case (uw.rsrc)
      RS_NONE: ram_re = 1'b0;
      RS_ROW:  ram_re = 1'b1;
      RS_ROW1: begin
        ram_re    = !flags.last_copy;
        ram_raddr = ptr_q + RowStep1;
      end
      RS_REQ: begin
        ram_re    = in_range;
        ram_raddr = lin_addr;
      end
      default: ram_re = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.ptr_op)
      PTR_HOLD: ptr_d = ptr_q;
      PTR_INC:  ptr_d = ptr_q + AddrW'(1);
      PTR_CLR:  ptr_d = '0;
      PTR_KEEP: ptr_d = ptr_q;
      default:  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    case (uw.cur_op)
      CUR_HOLD: begin
        row_d = row_q;
        col_d = col_q;
      end
      CUR_ADV: begin
        if (col_q == ColLast) begin
          col_d = '0;
          row_d = row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
      CUR_NEWROW: begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end
      CUR_BOTTOM: begin
        col_d = '0;
        row_d = RowLast;
      end
      default: begin
        row_d = row_q;
        col_d = col_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q   <= FORE_RESET;
      back_q   <= BACK_RESET;
      ptr_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_FORE)) begin
        fore_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_BACK)) begin
        back_q <= cfg_data_i;
      end
      ptr_q    <= ptr_d;
      row_q    <= row_d;
      col_q    <= col_d;
      strobe_q <= uw.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_i;
      cell_q   <= '0;
      scroll_q <= 1'b0;
    end else begin
      if (uw.load_cell) begin
        cell_q <= in_range ? ram_rdata : 16'h0000;
      end
      if (uw.cur_op == CUR_BOTTOM) begin
        scroll_q <= 1'b1;
      end
    end
    if (uw.emit) begin
      res_q.cell_value <= cell_q;
      res_q.cursor_row <= row_ext[4:0];
      res_q.cursor_col <= col_ext[6:0];
      res_q.did_scroll <= scroll_q;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  // Result strobes never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("result strobe held for two cycles");

  // An accepted command always makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command accepted without going busy");

  // Between commands the cursor lies on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (row_q < RowLimit) && (col_q <= ColLast))
    else $error("cursor off screen while idle");

  // A scroll always leaves the cursor at the start of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.did_scroll) |-> (res_o.cursor_col == 7'd0))
    else $error("scroll left cursor away from column zero");

endmodule
